// ----- hdl/green_function_kernel_eval_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the kernel evaluator
// Short forms for clocked implications under the asynchronous reset.
// ---------------------------------------------------------------------------
`ifndef GREEN_FUNCTION_KERNEL_EVAL_ASSERT_SVH
`define GREEN_FUNCTION_KERNEL_EVAL_ASSERT_SVH

// Same-cycle implication
`define GFK_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define GFK_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/gfk_pkg.sv -----
// ---------------------------------------------------------------------------
// gfk_pkg
// Types, constants and arithmetic helpers shared by the kernel evaluator.
// ---------------------------------------------------------------------------
`default_nettype none

package gfk_pkg;

	// Mode register codes
	typedef enum logic [1:0] {
		MODE_LAPLACE = 2'd0,
		MODE_STOKES  = 2'd1,
		MODE_NEUMANN = 2'd2
	} pde_mode_t;

	// Iterative stage counts: log squaring / ratio division, and rotlet division
	localparam int unsigned SQ_STAGES   = 32;
	localparam int unsigned LOOP_STAGES = 52;

	// ln(2)/2 and 1/(4*pi), both scaled by 2^32
	localparam logic [31:0] LN2_HALF = 32'd1488522236;
	localparam logic [31:0] S_Q32    = 32'd341782638;

	// Rotlet quotient ceiling
	localparam logic [51:0] ROT_CAP = 52'hF_FFFF_FFFF_FFFF;

	// Output range, Q16.32 in 48 bits
	localparam logic signed [53:0] CLIP_HI = 54'sh0_7FFF_FFFF_FFFF;
	localparam logic signed [53:0] CLIP_LO = -54'sh0_8000_0000_0000;
	localparam logic [47:0] MAX48 = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] MIN48 = 48'h8000_0000_0000;

	// State carried through the iterative stages
	typedef struct packed {
		logic [31:0]       m;
		logic [31:0]       frac;
		logic [6:0]        p;
		logic [61:0]       d;
		logic [2:0][61:0]  rat_rem;
		logic [2:0][32:0]  rat_q;
		logic [1:0][61:0]  rot_rem;
		logic [1:0][51:0]  rot_q;
		logic [1:0]        rot_cap;
		logic              zero;
		logic              neg_x;
		logic              neg_y;
		logic              pos_x;
	} gfk_loop_t;

	// One squaring step of the log2 mantissa: {emitted bit, next mantissa}
	function automatic logic [32:0] sq_step(input logic [31:0] m);
		logic [63:0] sq;
		sq = m * m;
		if (sq[63]) begin
			sq_step = {1'b1, sq[63:32]};
		end else begin
			sq_step = {1'b0, sq[62:31]};
		end
	endfunction

	// One restoring division step: {next remainder, quotient bit}
	function automatic logic [62:0] div_step(input logic [61:0] rem, input logic [61:0] d);
		logic [62:0] t;
		logic [62:0] diff;
		t    = {rem, 1'b0};
		diff = t - {1'b0, d};
		if (t >= {1'b0, d}) begin
			div_step = {diff[61:0], 1'b1};
		end else begin
			div_step = {t[61:0], 1'b0};
		end
	endfunction

	// Clip to 48 bits: {clipped flag, value}
	function automatic logic [48:0] clip48(input logic signed [53:0] v);
		if (v > CLIP_HI) begin
			clip48 = {1'b1, MAX48};
		end else if (v < CLIP_LO) begin
			clip48 = {1'b1, MIN48};
		end else begin
			clip48 = {1'b0, v[47:0]};
		end
	endfunction

endpackage

`default_nettype wire

// ----- hdl/gfk_if.sv -----
// ---------------------------------------------------------------------------
// gfk_in_if / gfk_out_if
// Valid/ready channels for point-pair requests and kernel results.
// ---------------------------------------------------------------------------
`default_nettype none

interface gfk_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] target_x;
	logic signed [31:0] target_y;
	logic signed [31:0] center_x;
	logic signed [31:0] center_y;

	modport source (output valid, output target_x, output target_y,
		output center_x, output center_y, input ready);
	modport sink (input valid, input target_x, input target_y,
		input center_x, input center_y, output ready);
endinterface

interface gfk_out_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] row0_col0;
	logic signed [47:0] row1_col0;
	logic signed [47:0] row0_col1;
	logic signed [47:0] row1_col1;
	logic signed [47:0] row0_col2;
	logic signed [47:0] row1_col2;
	logic               result_valid;
	logic               saturated;

	modport source (output valid, output row0_col0, output row1_col0,
		output row0_col1, output row1_col1, output row0_col2, output row1_col2,
		output result_valid, output saturated, input ready);
	modport sink (input valid, input row0_col0, input row1_col0,
		input row0_col1, input row1_col1, input row0_col2, input row1_col2,
		input result_valid, input saturated, output ready);
endinterface

`default_nettype wire

// ----- hdl/green_function_kernel_eval.sv -----
// Evaluates the 2-D Laplace log kernel or the Stokes 2x3 block for one
// target/centre pair per clock. The pipeline is 63 stages deep: six front
// stages, 52 iteration stages (the rotlet division yields one quotient bit a
// stage; the log squaring and ratio divisions finish in the first 32 of them)
// and five back stages ending in the output register. A request is taken in
// every cycle in which the output register is empty or being emptied; while
// a result waits the whole pipeline holds. The mode register must only be
// written with no request in flight.
// ---------------------------------------------------------------------------
// green_function_kernel_eval
// Top level: mode register, pipeline advance and stage chain.
// ---------------------------------------------------------------------------
`default_nettype none

module green_function_kernel_eval (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	gfk_in_if.sink     req,
	gfk_out_if.source  rsp
);
	import gfk_pkg::*;

	logic       adv;
	logic [1:0] pde_mode_q;
	logic       lv [0:LOOP_STAGES];
	gfk_loop_t  lp [0:LOOP_STAGES];

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pde_mode_q <= MODE_LAPLACE;
		end else if (cfg_we) begin
			pde_mode_q <= cfg_wdata;
		end
	end

	// Advance unless a result waits in the output register
	assign adv       = !rsp.valid || rsp.ready;
	assign req.ready = adv;

	gfk_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.req    (req),
		.vld    (lv[0]),
		.lp     (lp[0])
	);

	for (genvar g = 0; g < LOOP_STAGES; g++) begin : g_loop
		if (g < SQ_STAGES) begin : g_full
			gfk_step_full u_step (
				.clk    (clk),
				.arst_n (arst_n),
				.adv    (adv),
				.v_in   (lv[g]),
				.ld_in  (lp[g]),
				.v_out  (lv[g+1]),
				.ld_out (lp[g+1])
			);
		end else begin : g_rot
			gfk_step_rot u_step (
				.clk    (clk),
				.arst_n (arst_n),
				.adv    (adv),
				.v_in   (lv[g]),
				.ld_in  (lp[g]),
				.v_out  (lv[g+1]),
				.ld_out (lp[g+1])
			);
		end
	end

	gfk_tail u_tail (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.vld      (lv[LOOP_STAGES]),
		.lp       (lp[LOOP_STAGES]),
		.pde_mode (pde_mode_q),
		.rsp      (rsp)
	);

endmodule

`default_nettype wire

// ----- hdl/gfk_front.sv -----
// ---------------------------------------------------------------------------
// gfk_front
// Six-stage front end: difference, magnitude, squares, r^2, normalisation
// search and division set-up, then mantissa shift.
// ---------------------------------------------------------------------------
`default_nettype none

module gfk_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	gfk_in_if.sink            req,
	output logic              vld,
	output gfk_pkg::gfk_loop_t lp
);
	import gfk_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [32:0] rx_s1, ry_s1;
	logic [32:0]        rx_neg, ry_neg;

	logic [31:0] ax_s2, ay_s2;
	logic        neg_x_s2, neg_y_s2, pos_x_s2;

	logic [63:0] sx_s3, sy_s3, pxy_s3;
	logic [31:0] ax_s3, ay_s3;
	logic        neg_x_s3, neg_y_s3, pos_x_s3;

	logic [64:0] r2_s4;
	logic [63:0] sx_s4, sy_s4, pxy_s4;
	logic [31:0] ax_s4, ay_s4;
	logic        neg_x_s4, neg_y_s4, pos_x_s4;

	logic             big_c;
	logic [61:0]      d_c;
	logic [2:0][61:0] num_c;
	logic [2:0][61:0] rrem_c;
	logic [2:0]       rq_c;
	logic [1:0][61:0] nsh_c;
	logic [1:0]       cap_c;
	logic [6:0]       p_c;

	logic [64:0]      r2_s5;
	logic [6:0]       p_s5;
	logic [61:0]      d_s5;
	logic [2:0][61:0] rrem_s5;
	logic [2:0]       rq_s5;
	logic [1:0][61:0] nsh_s5;
	logic [1:0]       cap_s5;
	logic             zero_s5, neg_x_s5, neg_y_s5, pos_x_s5;

	logic [95:0] norm_c;
	gfk_loop_t   loop_s6;

	// Advance the valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Magnitudes of the offset
	assign rx_neg = -rx_s1;
	assign ry_neg = -ry_s1;

	// Division set-up and leading-one search on r^2
	always_comb begin
		big_c = |r2_s4[64:62];
		d_c   = big_c ? r2_s4[64:3] : r2_s4[61:0];
		num_c[0] = big_c ? {1'b0, sx_s4[63:3]}  : sx_s4[61:0];
		num_c[1] = big_c ? {1'b0, sy_s4[63:3]}  : sy_s4[61:0];
		num_c[2] = big_c ? {1'b0, pxy_s4[63:3]} : pxy_s4[61:0];
		for (int k = 0; k < 3; k++) begin
			rq_c[k]   = num_c[k] >= d_c;
			rrem_c[k] = rq_c[k] ? num_c[k] - d_c : num_c[k];
		end
		nsh_c[0] = big_c ? {29'b0, ay_s4, 1'b0} : {26'b0, ay_s4, 4'b0};
		nsh_c[1] = big_c ? {29'b0, ax_s4, 1'b0} : {26'b0, ax_s4, 4'b0};
		for (int j = 0; j < 2; j++) begin
			cap_c[j] = nsh_c[j] >= d_c;
		end
		p_c = '0;
		for (int i = 0; i < 65; i++) begin
			if (r2_s4[i]) begin
				p_c = 7'(i);
			end
		end
	end

	// Bring the leading one to bit 31
	assign norm_c = {r2_s5, 31'b0} >> p_s5;

	// Hold the payload on a stall
	always_ff @(posedge clk) begin
		if (adv) begin
			rx_s1 <= {req.target_x[31], req.target_x} - {req.center_x[31], req.center_x};
			ry_s1 <= {req.target_y[31], req.target_y} - {req.center_y[31], req.center_y};

			ax_s2    <= rx_s1[32] ? rx_neg[31:0] : rx_s1[31:0];
			ay_s2    <= ry_s1[32] ? ry_neg[31:0] : ry_s1[31:0];
			neg_x_s2 <= rx_s1[32];
			neg_y_s2 <= ry_s1[32];
			pos_x_s2 <= !rx_s1[32] && (rx_s1 != '0);

			sx_s3    <= ax_s2 * ax_s2;
			sy_s3    <= ay_s2 * ay_s2;
			pxy_s3   <= ax_s2 * ay_s2;
			ax_s3    <= ax_s2;
			ay_s3    <= ay_s2;
			neg_x_s3 <= neg_x_s2;
			neg_y_s3 <= neg_y_s2;
			pos_x_s3 <= pos_x_s2;

			r2_s4    <= {1'b0, sx_s3} + {1'b0, sy_s3};
			sx_s4    <= sx_s3;
			sy_s4    <= sy_s3;
			pxy_s4   <= pxy_s3;
			ax_s4    <= ax_s3;
			ay_s4    <= ay_s3;
			neg_x_s4 <= neg_x_s3;
			neg_y_s4 <= neg_y_s3;
			pos_x_s4 <= pos_x_s3;

			r2_s5    <= r2_s4;
			p_s5     <= p_c;
			d_s5     <= d_c;
			rrem_s5  <= rrem_c;
			rq_s5    <= rq_c;
			nsh_s5   <= nsh_c;
			cap_s5   <= cap_c;
			zero_s5  <= r2_s4 == '0;
			neg_x_s5 <= neg_x_s4;
			neg_y_s5 <= neg_y_s4;
			pos_x_s5 <= pos_x_s4;

			loop_s6.m       <= norm_c[31:0];
			loop_s6.frac    <= '0;
			loop_s6.p       <= p_s5;
			loop_s6.d       <= d_s5;
			loop_s6.rat_rem <= rrem_s5;
			for (int k = 0; k < 3; k++) begin
				loop_s6.rat_q[k] <= {32'b0, rq_s5[k]};
			end
			loop_s6.rot_rem <= nsh_s5;
			loop_s6.rot_q   <= '0;
			loop_s6.rot_cap <= cap_s5;
			loop_s6.zero    <= zero_s5;
			loop_s6.neg_x   <= neg_x_s5;
			loop_s6.neg_y   <= neg_y_s5;
			loop_s6.pos_x   <= pos_x_s5;
		end
	end

	assign vld = v_s6;
	assign lp  = loop_s6;

endmodule

`default_nettype wire

// ----- hdl/gfk_step_full.sv -----
// ---------------------------------------------------------------------------
// gfk_step_full
// One iteration stage: a log2 squaring step, a step of each of the three
// ratio divisions and a step of both rotlet divisions.
// ---------------------------------------------------------------------------
`default_nettype none

module gfk_step_full (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               v_in,
	input  gfk_pkg::gfk_loop_t ld_in,
	output logic               v_out,
	output gfk_pkg::gfk_loop_t ld_out
);
	import gfk_pkg::*;

	logic      vld_s1;
	gfk_loop_t loop_s1;
	gfk_loop_t nxt;
	logic [32:0] sq;
	logic [62:0] dv;

	// Squaring and division steps
	always_comb begin
		nxt  = ld_in;
		sq   = sq_step(ld_in.m);
		nxt.m    = sq[31:0];
		nxt.frac = {ld_in.frac[30:0], sq[32]};
		dv = '0;
		for (int k = 0; k < 3; k++) begin
			dv = div_step(ld_in.rat_rem[k], ld_in.d);
			nxt.rat_rem[k] = dv[62:1];
			nxt.rat_q[k]   = {ld_in.rat_q[k][31:0], dv[0]};
		end
		for (int j = 0; j < 2; j++) begin
			dv = div_step(ld_in.rot_rem[j], ld_in.d);
			nxt.rot_rem[j] = dv[62:1];
			nxt.rot_q[j]   = {ld_in.rot_q[j][50:0], dv[0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			loop_s1 <= nxt;
		end
	end

	assign v_out  = vld_s1;
	assign ld_out = loop_s1;

endmodule

`default_nettype wire

// ----- hdl/gfk_step_rot.sv -----
// ---------------------------------------------------------------------------
// gfk_step_rot
// One iteration stage of the two rotlet divisions; log and ratio results
// ride along unchanged.
// ---------------------------------------------------------------------------
`default_nettype none

module gfk_step_rot (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               v_in,
	input  gfk_pkg::gfk_loop_t ld_in,
	output logic               v_out,
	output gfk_pkg::gfk_loop_t ld_out
);
	import gfk_pkg::*;

	logic      vld_s1;
	gfk_loop_t loop_s1;
	gfk_loop_t nxt;
	logic [62:0] dv;

	// Rotlet division steps
	always_comb begin
		nxt = ld_in;
		dv  = '0;
		for (int j = 0; j < 2; j++) begin
			dv = div_step(ld_in.rot_rem[j], ld_in.d);
			nxt.rot_rem[j] = dv[62:1];
			nxt.rot_q[j]   = {ld_in.rot_q[j][50:0], dv[0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			loop_s1 <= nxt;
		end
	end

	assign v_out  = vld_s1;
	assign ld_out = loop_s1;

endmodule

`default_nettype wire

// ----- hdl/gfk_tail.sv -----
// ---------------------------------------------------------------------------
// gfk_tail
// Five-stage back end: log assembly, scaling by 1/(4*pi), signs, clipping,
// mode selection and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module gfk_tail (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               vld,
	input  gfk_pkg::gfk_loop_t lp,
	input  logic [1:0]         pde_mode,
	gfk_out_if.source          rsp
);
	import gfk_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// Stage 1 products
	logic [63:0]        flp_c;
	logic signed [7:0]  pe_c;
	logic [2:0][63:0]   rlo_c;
	logic [1:0][51:0]   qe_c;
	logic [1:0][63:0]   rotlo_c;
	logic [31:0]        fl_s1;
	logic signed [40:0] pl_s1;
	logic [2:0][31:0]   rlo_s1;
	logic [2:0]         rhi_s1;
	logic [1:0][51:0]   rothi_s1;
	logic [1:0][31:0]   rotlo_s1;
	logic               zero_s1, neg_x_s1, neg_y_s1, pos_x_s1;

	// Stage 2 sums
	logic signed [40:0] lg_s2;
	logic [2:0][32:0]   rat_s2;
	logic [1:0][52:0]   rot_s2;
	logic               zero_s2, neg_x_s2, neg_y_s2, pos_x_s2;

	// Stage 3 scaling of |log|
	logic [40:0]        alg_c;
	logic [63:0]        sllo_c;
	logic [40:0]        slhi_s3;
	logic [31:0]        sllo_s3;
	logic               slneg_s3;
	logic signed [40:0] lg_s3;
	logic [2:0][32:0]   rat_s3;
	logic [1:0][52:0]   rot_s3;
	logic               zero_s3, neg_x_s3, neg_y_s3, pos_x_s3;

	// Stage 4 signed log term
	logic [41:0]        slm_c;
	logic signed [42:0] sl_s4;
	logic signed [40:0] lg_s4;
	logic [2:0][32:0]   rat_s4;
	logic [1:0][52:0]   rot_s4;
	logic               zero_s4, neg_x_s4, neg_y_s4, pos_x_s4;

	// Output stage
	logic signed [53:0] sl_c, txx_c, tyy_c, txy_c, r0_c, r1_c, mag_c;
	logic [48:0]        cxx, cyy, cxy, cr0, cr1, clg;
	logic [47:0]        o00_c, o10_c, o01_c, o11_c, o02_c, o12_c;
	logic               ov_c, os_c;
	logic [47:0]        row0_col0_s5, row1_col0_s5, row0_col1_s5;
	logic [47:0]        row1_col1_s5, row0_col2_s5, row1_col2_s5;
	logic               result_valid_s5, saturated_s5;

	// Advance the valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Fraction and quotient products
	always_comb begin
		flp_c = lp.frac * LN2_HALF;
		pe_c  = $signed({1'b0, lp.p}) - 8'sd48;
		for (int k = 0; k < 3; k++) begin
			rlo_c[k] = lp.rat_q[k][31:0] * S_Q32;
		end
		for (int j = 0; j < 2; j++) begin
			qe_c[j]    = lp.rot_cap[j] ? ROT_CAP : lp.rot_q[j];
			rotlo_c[j] = qe_c[j][31:0] * S_Q32;
		end
	end

	// Magnitude of the log and its scaled low half
	always_comb begin
		alg_c  = lg_s2[40] ? 41'(-lg_s2) : 41'(lg_s2);
		sllo_c = alg_c[31:0] * S_Q32;
		slm_c  = {1'b0, slhi_s3} + {10'b0, sllo_s3};
	end

	// Sign, clip and select by mode
	always_comb begin
		sl_c  = 54'(sl_s4);
		txx_c = sl_c + $signed(54'(rat_s4[0]));
		tyy_c = sl_c + $signed(54'(rat_s4[1]));
		mag_c = $signed(54'(rat_s4[2]));
		txy_c = (neg_x_s4 != neg_y_s4) ? -mag_c : mag_c;
		r0_c  = neg_y_s4 ? -$signed(54'(rot_s4[0])) : $signed(54'(rot_s4[0]));
		r1_c  = pos_x_s4 ? -$signed(54'(rot_s4[1])) : $signed(54'(rot_s4[1]));
		cxx = clip48(txx_c);
		cyy = clip48(tyy_c);
		cxy = clip48(txy_c);
		cr0 = clip48(r0_c);
		cr1 = clip48(r1_c);
		clg = clip48(54'(lg_s4));

		o00_c = '0;
		o10_c = '0;
		o01_c = '0;
		o11_c = '0;
		o02_c = '0;
		o12_c = '0;
		ov_c  = 1'b0;
		os_c  = 1'b0;
		unique case (pde_mode)
			MODE_LAPLACE: begin
				ov_c = 1'b1;
				if (zero_s4) begin
					o00_c = MIN48;
					os_c  = 1'b1;
				end else begin
					o00_c = clg[47:0];
					os_c  = clg[48];
				end
			end
			MODE_STOKES: begin
				ov_c = 1'b1;
				if (zero_s4) begin
					o00_c = MAX48;
					o11_c = MAX48;
					os_c  = 1'b1;
				end else begin
					o00_c = cxx[47:0];
					o10_c = cxy[47:0];
					o01_c = cxy[47:0];
					o11_c = cyy[47:0];
					o02_c = cr0[47:0];
					o12_c = cr1[47:0];
					os_c  = cxx[48] | cxy[48] | cyy[48] | cr0[48] | cr1[48];
				end
			end
			default: begin
				ov_c = 1'b0;
			end
		endcase
	end

	// Hold the payload on a stall
	always_ff @(posedge clk) begin
		if (adv) begin
			fl_s1    <= flp_c[63:32];
			pl_s1    <= pe_c * $signed({1'b0, LN2_HALF});
			for (int k = 0; k < 3; k++) begin
				rlo_s1[k] <= rlo_c[k][63:32];
				rhi_s1[k] <= lp.rat_q[k][32];
			end
			for (int j = 0; j < 2; j++) begin
				rothi_s1[j] <= qe_c[j][51:32] * S_Q32;
				rotlo_s1[j] <= rotlo_c[j][63:32];
			end
			zero_s1  <= lp.zero;
			neg_x_s1 <= lp.neg_x;
			neg_y_s1 <= lp.neg_y;
			pos_x_s1 <= lp.pos_x;

			lg_s2 <= pl_s1 + $signed({9'b0, fl_s1});
			for (int k = 0; k < 3; k++) begin
				rat_s2[k] <= (rhi_s1[k] ? {1'b0, S_Q32} : 33'd0) + {1'b0, rlo_s1[k]};
			end
			for (int j = 0; j < 2; j++) begin
				rot_s2[j] <= {1'b0, rothi_s1[j]} + {21'b0, rotlo_s1[j]};
			end
			zero_s2  <= zero_s1;
			neg_x_s2 <= neg_x_s1;
			neg_y_s2 <= neg_y_s1;
			pos_x_s2 <= pos_x_s1;

			slhi_s3  <= alg_c[40:32] * S_Q32;
			sllo_s3  <= sllo_c[63:32];
			slneg_s3 <= !lg_s2[40];
			lg_s3    <= lg_s2;
			rat_s3   <= rat_s2;
			rot_s3   <= rot_s2;
			zero_s3  <= zero_s2;
			neg_x_s3 <= neg_x_s2;
			neg_y_s3 <= neg_y_s2;
			pos_x_s3 <= pos_x_s2;

			sl_s4    <= slneg_s3 ? -$signed({1'b0, slm_c}) : $signed({1'b0, slm_c});
			lg_s4    <= lg_s3;
			rat_s4   <= rat_s3;
			rot_s4   <= rot_s3;
			zero_s4  <= zero_s3;
			neg_x_s4 <= neg_x_s3;
			neg_y_s4 <= neg_y_s3;
			pos_x_s4 <= pos_x_s3;

			row0_col0_s5    <= o00_c;
			row1_col0_s5    <= o10_c;
			row0_col1_s5    <= o01_c;
			row1_col1_s5    <= o11_c;
			row0_col2_s5    <= o02_c;
			row1_col2_s5    <= o12_c;
			result_valid_s5 <= ov_c;
			saturated_s5    <= os_c;
		end
	end

	assign rsp.valid        = v_s5;
	assign rsp.row0_col0    = row0_col0_s5;
	assign rsp.row1_col0    = row1_col0_s5;
	assign rsp.row0_col1    = row0_col1_s5;
	assign rsp.row1_col1    = row1_col1_s5;
	assign rsp.row0_col2    = row0_col2_s5;
	assign rsp.row1_col2    = row1_col2_s5;
	assign rsp.result_valid = result_valid_s5;
	assign rsp.saturated    = saturated_s5;

endmodule

`default_nettype wire

// ----- hdl/gfk_checker.sv -----
// ---------------------------------------------------------------------------
// gfk_checker
// Port-level checks on the kernel evaluator, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "green_function_kernel_eval_assert.svh"

module gfk_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [47:0] row0_col0,
	input logic [47:0] row1_col0,
	input logic [47:0] row0_col1,
	input logic [47:0] row1_col1,
	input logic [47:0] row0_col2,
	input logic [47:0] row1_col2,
	input logic        result_valid,
	input logic        saturated
);

	// A result not taken stays offered
	`GFK_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped")

	// Requests flow whenever the output side is free
	`GFK_ASSERT_IMP(a_ready, clk, arst_n, in_valid || !in_valid, in_ready == (!out_valid || out_ready), "ready mismatch")

	// A result without values carries only zeros
	`GFK_ASSERT_IMP(a_empty, clk, arst_n, out_valid && !result_valid, row0_col0 == 48'd0 && row1_col0 == 48'd0 && row0_col1 == 48'd0 && row1_col1 == 48'd0 && row0_col2 == 48'd0 && row1_col2 == 48'd0 && !saturated, "empty result not zero")

	// Off-diagonal Stokeslet terms agree
	`GFK_ASSERT_IMP(a_sym, clk, arst_n, out_valid && result_valid, row1_col0 == row0_col1, "off-diagonal mismatch")

endmodule

bind green_function_kernel_eval gfk_checker u_gfk_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (req.valid),
	.in_ready     (req.ready),
	.out_valid    (rsp.valid),
	.out_ready    (rsp.ready),
	.row0_col0    (rsp.row0_col0),
	.row1_col0    (rsp.row1_col0),
	.row0_col1    (rsp.row0_col1),
	.row1_col1    (rsp.row1_col1),
	.row0_col2    (rsp.row0_col2),
	.row1_col2    (rsp.row1_col2),
	.result_valid (rsp.result_valid),
	.saturated    (rsp.saturated)
);

`default_nettype wire
